FILE: rtl/core/c8core_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_pkg
// Types, codes, font table and small helper functions shared by the core.
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int SCR_COLS    = 64;
    localparam int SCR_ROWS    = 32;
    localparam int ROW_AW      = $clog2(SCR_ROWS);
    localparam int COL_AW      = $clog2(SCR_COLS);
    localparam int NUM_VREGS   = 16;
    localparam int VREG_AW     = $clog2(NUM_VREGS);
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam logic [MEM_AW-1:0] START_ADDR = MEM_AW'(512);
    localparam logic [MEM_AW-1:0] FONT_BASE  = MEM_AW'(80);
    localparam int FONT_BYTES  = 80;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [2:0] {
        M_LOAD    = 3'd0,
        M_EXEC    = 3'd1,
        M_TICK    = 3'd2,
        M_RESTART = 3'd3,
        M_ROW     = 3'd4
    } t_mode;

    typedef enum logic [4:0] {
        K_NONE, K_CLS, K_RET, K_JP, K_CALL, K_SE, K_SNE, K_SER, K_LD, K_ADD,
        K_ALU, K_SNER, K_LDI, K_JPV0, K_RND, K_DRW, K_SKP, K_SKNP, K_LDDT,
        K_WKEY, K_SDT, K_SST, K_ADDI, K_FONT, K_BCD, K_STR, K_LDR
    } t_kind;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_MODE, S_FETCH1, S_FETCH2, S_FETCH3, S_RDX, S_RDY,
        S_RD0, S_EXEC, S_WRX, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
        S_DR_RD, S_DR_WR, S_DR_VF, S_ROW1, S_ROW2, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_INIT, C_IDLE, C_MODE, C_FETCH1, C_FETCH2, C_FETCH3, C_RDX, C_RDY,
        C_RD0, C_EXEC, C_WRX, C_BCD, C_ST_RD, C_ST_WR, C_LD_RD, C_LD_WR,
        C_DR_RD, C_DR_WR, C_DR_VF, C_ROW1, C_ROW2, C_DONE
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        t_kind      kind;
        logic       n_zero;
        logic       loop_last;
        logic       bcd_last;
        logic       draw_last;
        logic       init_last;
    } t_stat;

    function automatic t_kind decode(input logic [15:0] op);
        t_kind k;
        k = K_NONE;
        unique case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) k = K_CLS;
                else if (op == 16'h00EE) k = K_RET;
            end
            4'h1: k = K_JP;
            4'h2: k = K_CALL;
            4'h3: k = K_SE;
            4'h4: k = K_SNE;
            4'h5: k = K_SER;
            4'h6: k = K_LD;
            4'h7: k = K_ADD;
            4'h8: k = K_ALU;
            4'h9: k = K_SNER;
            4'hA: k = K_LDI;
            4'hB: k = K_JPV0;
            4'hC: k = K_RND;
            4'hD: k = K_DRW;
            4'hE: begin
                if (op[7:0] == 8'h9E) k = K_SKP;
                else if (op[7:0] == 8'hA1) k = K_SKNP;
            end
            default: begin
                unique case (op[7:0])
                    8'h07:   k = K_LDDT;
                    8'h0A:   k = K_WKEY;
                    8'h15:   k = K_SDT;
                    8'h18:   k = K_SST;
                    8'h1E:   k = K_ADDI;
                    8'h29:   k = K_FONT;
                    8'h33:   k = K_BCD;
                    8'h55:   k = K_STR;
                    8'h65:   k = K_LDR;
                    default: k = K_NONE;
                endcase
            end
        endcase
        return k;
    endfunction

    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
        logic [MEM_AW-1:0] d;
        d = a - FONT_BASE;
        if (d < MEM_AW'(FONT_BYTES)) return FONT[d[6:0]];
        return 8'h00;
    endfunction

    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [7:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - (8'(h) * 8'd100);
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = r - (8'(t) * 8'd10);
        unique case (sel)
            2'd0:    return {6'b0, h};
            2'd1:    return {4'b0, t};
            default: return o;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/c8core_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/c8core_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_ctrl
// Sequencer: steps each beat through its mode step and, for execute beats, fetch, operand read, execute and loops.
// ----------------------------------------------------------------------------
module c8core_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire c8core_pkg::t_stat    i_stat,
    output c8core_pkg::t_cmd          o_cmd,
    output logic                      o_busy,
    output logic                      o_done
);
    import c8core_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_IDLE;
        unique case (r_state)
            S_INIT: begin
                o_cmd = C_INIT;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd = C_IDLE;
                if (i_start) n_state = S_MODE;
            end
            S_MODE: begin
                o_cmd = C_MODE;
                if (i_stat.mode == M_EXEC)     n_state = S_FETCH1;
                else if (i_stat.mode == M_ROW) n_state = S_ROW1;
                else                           n_state = S_DONE;
            end
            S_FETCH1: begin o_cmd = C_FETCH1; n_state = S_FETCH2; end
            S_FETCH2: begin o_cmd = C_FETCH2; n_state = S_FETCH3; end
            S_FETCH3: begin o_cmd = C_FETCH3; n_state = S_RDX;    end
            S_RDX:    begin o_cmd = C_RDX;    n_state = S_RDY;    end
            S_RDY:    begin o_cmd = C_RDY;    n_state = S_RD0;    end
            S_RD0:    begin o_cmd = C_RD0;    n_state = S_EXEC;   end
            S_EXEC: begin
                o_cmd = C_EXEC;
                unique case (i_stat.kind)
                    K_DRW:   n_state = i_stat.n_zero ? S_DR_VF : S_DR_RD;
                    K_BCD:   n_state = S_BCD;
                    K_STR:   n_state = S_ST_RD;
                    K_LDR:   n_state = S_LD_RD;
                    default: n_state = S_WRX;
                endcase
            end
            S_WRX: begin o_cmd = C_WRX; n_state = S_DONE; end
            S_BCD: begin
                o_cmd = C_BCD;
                if (i_stat.bcd_last) n_state = S_DONE;
            end
            S_ST_RD: begin o_cmd = C_ST_RD; n_state = S_ST_WR; end
            S_ST_WR: begin
                o_cmd   = C_ST_WR;
                n_state = i_stat.loop_last ? S_DONE : S_ST_RD;
            end
            S_LD_RD: begin o_cmd = C_LD_RD; n_state = S_LD_WR; end
            S_LD_WR: begin
                o_cmd   = C_LD_WR;
                n_state = i_stat.loop_last ? S_DONE : S_LD_RD;
            end
            S_DR_RD: begin o_cmd = C_DR_RD; n_state = S_DR_WR; end
            S_DR_WR: begin
                o_cmd   = C_DR_WR;
                n_state = i_stat.draw_last ? S_DR_VF : S_DR_RD;
            end
            S_DR_VF: begin o_cmd = C_DR_VF; n_state = S_DONE; end
            S_ROW1:  begin o_cmd = C_ROW1;  n_state = S_ROW2; end
            S_ROW2:  begin o_cmd = C_ROW2;  n_state = S_DONE; end
            S_DONE:  begin o_cmd = C_DONE;  n_state = S_IDLE; end
            default: begin o_cmd = C_IDLE;  n_state = S_IDLE; end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule
`default_nettype wire

FILE: rtl/core/c8core_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8core_dp
// Datapath: memories, machine registers, ALU, draw and block-move logic.
// ----------------------------------------------------------------------------
module c8core_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire c8core_pkg::t_cmd     i_cmd,
    input  wire logic [2:0]           i_mode,
    input  wire logic [11:0]          i_address,
    input  wire logic [7:0]           i_write_byte,
    input  wire logic [15:0]          i_keys_down,
    input  wire logic [7:0]           i_random_byte,
    output c8core_pkg::t_stat         o_stat,
    output logic [11:0]               o_program_counter,
    output logic [15:0]               o_last_opcode,
    output logic                      o_sound_on,
    output logic                      o_waiting_key,
    output logic                      o_display_changed,
    output logic [63:0]               o_display_row
);
    import c8core_pkg::*;

    // latched beat
    logic [2:0]  r_mode;
    logic [11:0] r_addr;
    logic [7:0]  r_wbyte;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;

    // machine state
    logic [MEM_AW-1:0] r_pc, n_pc;
    logic [15:0]       r_op, n_op;
    logic [15:0]       r_i, n_i;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [7:0]        r_dt, n_dt;
    logic [7:0]        r_st, n_st;
    logic [MEM_AW-1:0] r_stack [STACK_DEPTH];
    logic              stk_we;
    logic [NUM_VREGS-1:0] r_vval;
    logic [SCR_ROWS-1:0]  r_fval;
    logic              vval_clr, fval_clr;

    // working registers
    logic [7:0]        r_va, n_va;
    logic [7:0]        r_vb, n_vb;
    logic [7:0]        r_res, n_res;
    logic              r_wrx, n_wrx;
    logic [MEM_AW-1:0] r_cnt, n_cnt;
    logic              r_coll, n_coll;
    logic              r_wait, n_wait;
    logic              r_chg, n_chg;
    logic [63:0]       r_row, n_row;
    logic              r_vok, r_fok;

    // memory ports
    logic              m_we;
    logic [MEM_AW-1:0] m_waddr, m_raddr;
    logic [7:0]        m_wdata, m_rdata;
    logic              v_we;
    logic [VREG_AW-1:0] v_waddr, v_raddr;
    logic [7:0]        v_wdata, v_rdata, vr;
    logic              f_we;
    logic [ROW_AW-1:0] f_waddr, f_raddr;
    logic [63:0]       f_wdata, f_rdata, fr, mask;

    c8core_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );
    c8core_ram #(.WIDTH(8), .DEPTH(NUM_VREGS)) u_vreg (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    c8core_ram #(.WIDTH(64), .DEPTH(SCR_ROWS)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    t_kind              kind;
    logic [VREG_AW-1:0] fx, fy;
    logic [3:0]         fn;
    logic [7:0]         kk;
    logic [MEM_AW-1:0]  nnn, icnt, pc2;
    logic [ROW_AW-1:0]  row0;
    logic [COL_AW-1:0]  col0;
    logic [ROW_AW:0]    row_next;
    logic [8:0]         sum;
    logic               kfound;
    logic [3:0]         kidx;

    assign kind = decode(r_op);
    assign fx   = r_op[11:8];
    assign fy   = r_op[7:4];
    assign fn   = r_op[3:0];
    assign kk   = r_op[7:0];
    assign nnn  = r_op[11:0];
    assign icnt = r_i[MEM_AW-1:0] + r_cnt;
    assign pc2  = r_pc + MEM_AW'(2);
    assign row0 = r_vb[ROW_AW-1:0];
    assign col0 = r_va[COL_AW-1:0];
    assign row_next = {1'b0, row0} + (ROW_AW+1)'(r_cnt[3:0]) + (ROW_AW+1)'(1);
    assign vr   = r_vok ? v_rdata : 8'h00;
    assign fr   = r_fok ? f_rdata : 64'h0;
    assign mask = {m_rdata, 56'h0} >> col0;
    assign sum  = {1'b0, r_va} + {1'b0, r_vb};

    always_comb begin
        kfound = 1'b0;
        kidx   = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                kfound = 1'b1;
                kidx   = 4'(k);
            end
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.kind      = kind;
        o_stat.n_zero    = (fn == 4'd0);
        o_stat.loop_last = (r_cnt[VREG_AW-1:0] == fx);
        o_stat.bcd_last  = (r_cnt[1:0] == 2'd2);
        o_stat.draw_last = (r_cnt[3:0] == fn - 4'd1) || row_next[ROW_AW];
        o_stat.init_last = (r_cnt == MEM_AW'(MEM_BYTES - 1));
    end

    always_comb begin
        n_pc = r_pc;   n_op = r_op;   n_i = r_i;     n_sp = r_sp;
        n_dt = r_dt;   n_st = r_st;   n_va = r_va;   n_vb = r_vb;
        n_res = r_res; n_wrx = r_wrx; n_cnt = r_cnt; n_coll = r_coll;
        n_wait = r_wait; n_chg = r_chg; n_row = r_row;
        stk_we = 1'b0; vval_clr = 1'b0; fval_clr = 1'b0;
        m_we = 1'b0; m_waddr = icnt; m_wdata = 8'h00; m_raddr = r_pc;
        v_we = 1'b0; v_waddr = fx; v_wdata = r_res; v_raddr = fx;
        f_we = 1'b0; f_waddr = row0 + r_cnt[ROW_AW-1:0]; f_wdata = fr ^ mask;
        f_raddr = row0 + r_cnt[ROW_AW-1:0];
        unique case (i_cmd)
            C_INIT: begin
                m_we    = 1'b1;
                m_waddr = r_cnt;
                m_wdata = font_byte(r_cnt);
                n_cnt   = r_cnt + MEM_AW'(1);
            end
            C_IDLE: begin
                n_wait = 1'b0;
                n_chg  = 1'b0;
                n_row  = 64'h0;
            end
            C_MODE: begin
                case (r_mode)
                    M_LOAD: begin
                        m_we    = 1'b1;
                        m_waddr = r_addr;
                        m_wdata = r_wbyte;
                    end
                    M_TICK: begin
                        if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                        if (r_st != 8'd0) n_st = r_st - 8'd1;
                    end
                    M_RESTART: begin
                        n_pc = START_ADDR; n_sp = '0; n_op = 16'h0; n_i = 16'h0;
                        n_dt = 8'h0; n_st = 8'h0;
                        vval_clr = 1'b1; fval_clr = 1'b1; n_chg = 1'b1;
                    end
                    default: ;
                endcase
            end
            C_FETCH1: m_raddr = r_pc;
            C_FETCH2: begin
                m_raddr = r_pc + MEM_AW'(1);
                n_op    = {m_rdata, r_op[7:0]};
            end
            C_FETCH3: begin
                n_op = {r_op[15:8], m_rdata};
                n_pc = pc2;
            end
            C_RDX: v_raddr = fx;
            C_RDY: begin v_raddr = fy; n_va = vr; end
            C_RD0: begin v_raddr = '0; n_vb = vr; end
            C_EXEC: begin
                n_wrx  = 1'b0;
                n_cnt  = '0;
                n_coll = 1'b0;
                v_waddr = VREG_AW'(NUM_VREGS - 1);
                unique case (kind)
                    K_CLS:  begin fval_clr = 1'b1; n_chg = 1'b1; end
                    K_RET:  begin
                        n_sp = r_sp - SP_W'(1);
                        n_pc = r_stack[r_sp - SP_W'(1)];
                    end
                    K_JP:   n_pc = nnn;
                    K_CALL: begin stk_we = 1'b1; n_sp = r_sp + SP_W'(1); n_pc = nnn; end
                    K_SE:   if (r_va == kk) n_pc = pc2;
                    K_SNE:  if (r_va != kk) n_pc = pc2;
                    K_SER:  if (r_va == r_vb) n_pc = pc2;
                    K_SNER: if (r_va != r_vb) n_pc = pc2;
                    K_LD:   begin n_res = kk; n_wrx = 1'b1; end
                    K_ADD:  begin n_res = r_va + kk; n_wrx = 1'b1; end
                    K_ALU: begin
                        n_wrx = 1'b1;
                        case (fn)
                            4'h0: n_res = r_vb;
                            4'h1: n_res = r_va | r_vb;
                            4'h2: n_res = r_va & r_vb;
                            4'h3: n_res = r_va ^ r_vb;
                            4'h4: begin
                                n_res = sum[7:0]; v_we = 1'b1; v_wdata = {7'b0, sum[8]};
                            end
                            4'h5: begin
                                n_res = r_va - r_vb; v_we = 1'b1;
                                v_wdata = {7'b0, r_va > r_vb};
                            end
                            4'h6: begin
                                n_res = {1'b0, r_va[7:1]}; v_we = 1'b1;
                                v_wdata = {7'b0, r_va[0]};
                            end
                            4'h7: begin
                                n_res = r_vb - r_va; v_we = 1'b1;
                                v_wdata = {7'b0, r_vb > r_va};
                            end
                            4'hE: begin
                                n_res = {r_va[6:0], 1'b0}; v_we = 1'b1;
                                v_wdata = {7'b0, r_va[7]};
                            end
                            default: n_wrx = 1'b0;
                        endcase
                    end
                    K_LDI:  n_i = {4'h0, nnn};
                    K_JPV0: n_pc = nnn + MEM_AW'(vr);
                    K_RND:  begin n_res = r_rnd & kk; n_wrx = 1'b1; end
                    K_DRW:  n_chg = 1'b1;
                    K_SKP:  if (r_va < 8'd16 && r_keys[r_va[3:0]]) n_pc = pc2;
                    K_SKNP: if (!(r_va < 8'd16 && r_keys[r_va[3:0]])) n_pc = pc2;
                    K_LDDT: begin n_res = r_dt; n_wrx = 1'b1; end
                    K_WKEY: begin
                        if (kfound) begin
                            n_res = {4'h0, kidx}; n_wrx = 1'b1;
                        end else begin
                            n_pc = r_pc - MEM_AW'(2); n_wait = 1'b1;
                        end
                    end
                    K_SDT:  n_dt = r_va;
                    K_SST:  n_st = r_va;
                    K_ADDI: n_i = r_i + {8'h0, r_va};
                    K_FONT: n_i = 16'(FONT_BASE) + {6'h0, r_va, 2'b0} + {8'h0, r_va};
                    default: ;
                endcase
            end
            C_WRX: begin
                v_we = r_wrx; v_waddr = fx; v_wdata = r_res;
            end
            C_BCD: begin
                m_we = 1'b1; m_waddr = icnt; m_wdata = bcd_digit(r_va, r_cnt[1:0]);
                n_cnt = r_cnt + MEM_AW'(1);
            end
            C_ST_RD: v_raddr = r_cnt[VREG_AW-1:0];
            C_ST_WR: begin
                m_we = 1'b1; m_waddr = icnt; m_wdata = vr;
                n_cnt = r_cnt + MEM_AW'(1);
            end
            C_LD_RD: m_raddr = icnt;
            C_LD_WR: begin
                v_we = 1'b1; v_waddr = r_cnt[VREG_AW-1:0]; v_wdata = m_rdata;
                n_cnt = r_cnt + MEM_AW'(1);
            end
            C_DR_RD: begin
                m_raddr = icnt;
                f_raddr = row0 + r_cnt[ROW_AW-1:0];
            end
            C_DR_WR: begin
                f_we = 1'b1;
                if ((fr & mask) != 64'h0) n_coll = 1'b1;
                n_cnt = r_cnt + MEM_AW'(1);
            end
            C_DR_VF: begin
                v_we = 1'b1; v_waddr = VREG_AW'(NUM_VREGS - 1); v_wdata = {7'b0, r_coll};
            end
            C_ROW1: f_raddr = r_addr[ROW_AW-1:0];
            C_ROW2: n_row = fr;
            C_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= START_ADDR; r_op <= 16'h0; r_i <= 16'h0; r_sp <= '0;
            r_dt <= 8'h0; r_st <= 8'h0; r_cnt <= '0; r_vval <= '0; r_fval <= '0;
            r_wait <= 1'b0; r_chg <= 1'b0; r_row <= 64'h0; r_wrx <= 1'b0;
            r_coll <= 1'b0;
            for (int s = 0; s < STACK_DEPTH; s++) r_stack[s] <= '0;
        end else begin
            r_pc <= n_pc; r_op <= n_op; r_i <= n_i; r_sp <= n_sp;
            r_dt <= n_dt; r_st <= n_st; r_cnt <= n_cnt;
            r_wait <= n_wait; r_chg <= n_chg; r_row <= n_row; r_wrx <= n_wrx;
            r_coll <= n_coll;
            if (stk_we) r_stack[r_sp] <= r_pc;
            if (vval_clr)  r_vval <= '0;
            else if (v_we) r_vval[v_waddr] <= 1'b1;
            if (fval_clr)  r_fval <= '0;
            else if (f_we) r_fval[f_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va  <= n_va;
        r_vb  <= n_vb;
        r_res <= n_res;
        r_vok <= r_vval[v_raddr];
        r_fok <= r_fval[f_raddr];
        if (i_cmd == C_IDLE && i_start) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wbyte <= i_write_byte;
            r_keys  <= i_keys_down;
            r_rnd   <= i_random_byte;
        end
    end

    assign o_program_counter = r_pc;
    assign o_last_opcode     = r_op;
    assign o_sound_on        = (r_st != 8'h0);
    assign o_waiting_key     = r_wait;
    assign o_display_changed = r_chg;
    assign o_display_row     = r_row;
endmodule
`default_nettype wire

FILE: rtl/core/chip8_interpreter_core_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_interpreter_core_top
// CHIP-8 core: one command beat in, one result beat out.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. It carries
// a mode (load byte, execute, timer tick, restart, read display row) with
// address, write byte, keypad bitmap and random byte.
// Each beat gives exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall it. busy falls the cycle after o_done.
// Load, tick, restart and unused modes finish after the mode step; a row
// read adds the row-read states; instructions go through fetch, operand
// read and execute, then FX55 and FX65 loop over V0..VX, FX33 writes
// three digits and DXYN reads and writes each drawn line. The steps
// follow from the one read port of program memory and of the register
// file. Beats are handled one at a time.
// After reset the core sweeps program memory, writing the font and zeroing
// the rest: busy stays high until the sweep is done, before the first beat.
// ----------------------------------------------------------------------------
module chip8_interpreter_core_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             o_done,
    input  wire logic [2:0]  i_mode,
    input  wire logic [11:0] i_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [15:0] i_keys_down,
    input  wire logic [7:0]  i_random_byte,
    output logic [11:0]      o_program_counter,
    output logic [15:0]      o_last_opcode,
    output logic             o_sound_on,
    output logic             o_waiting_key,
    output logic             o_display_changed,
    output logic [63:0]      o_display_row
);
    import c8core_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    c8core_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(stat),
        .o_cmd(cmd), .o_busy(busy), .o_done(o_done)
    );

    c8core_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_cmd(cmd),
        .i_mode(i_mode), .i_address(i_address), .i_write_byte(i_write_byte),
        .i_keys_down(i_keys_down), .i_random_byte(i_random_byte), .o_stat(stat),
        .o_program_counter(o_program_counter), .o_last_opcode(o_last_opcode),
        .o_sound_on(o_sound_on), .o_waiting_key(o_waiting_key),
        .o_display_changed(o_display_changed), .o_display_row(o_display_row)
    );
endmodule
`default_nettype wire
